@@ hw/rtl/mrfp_pkg.sv @@
// Shared types and constants for the motor reply frame parser.
// Used by the deframer, the result register and the top under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package mrfp_pkg;

	localparam int MAX_FRAME_DEF = 128;

	// framing bytes
	localparam logic [7:0] SOF_BYTE = 8'h7e;
	localparam logic [7:0] EOF_BYTE = 8'h7f;
	localparam logic [7:0] ACK_REQ_BYTE = 8'h11;

	// configuration register indexes
	localparam logic CFG_EXP_OP   = 1'b0;
	localparam logic CFG_EXP_ATTR = 1'b1;

	// operation codes, low six bits
	localparam logic [5:0] OP_RUN         = 6'h03;
	localparam logic [5:0] OP_STOP        = 6'h08;
	localparam logic [5:0] OP_ESTOP       = 6'h09;
	localparam logic [5:0] OP_BRAKE       = 6'h0a;
	localparam logic [5:0] OP_SERVO_ON    = 6'h0e;
	localparam logic [5:0] OP_SERVO_OFF   = 6'h0f;
	localparam logic [5:0] OP_ERR_INFO    = 6'h10;
	localparam logic [5:0] OP_ERR_REPORT  = 6'h11;
	localparam logic [5:0] OP_RESET_ERR   = 6'h12;
	localparam logic [5:0] OP_CHECK_CONN  = 6'h22;
	localparam logic [5:0] OP_READ        = 6'h01;
	localparam logic [5:0] OP_WRITE       = 6'h05;

	// top two operation bits that mean a positive reply
	localparam logic [1:0] TOP_ACK_A = 2'b11;
	localparam logic [1:0] TOP_ACK_B = 2'b10;

	// attribute codes
	localparam logic [15:0] ATTR_DEV_ID  = 16'h0004;
	localparam logic [15:0] ATTR_MODE    = 16'h0001;
	localparam logic [15:0] ATTR_POS     = 16'h0011;
	localparam logic [15:0] ATTR_SPEED   = 16'h0021;
	localparam logic [15:0] ATTR_WPOS    = 16'h001d;
	localparam logic [15:0] ATTR_OFFSET  = 16'h001f;
	localparam logic [15:0] ATTR_ROLL    = 16'h0022;

	// command kinds
	localparam logic [4:0] KIND_RUN         = 5'd0;
	localparam logic [4:0] KIND_STOP        = 5'd1;
	localparam logic [4:0] KIND_ESTOP       = 5'd2;
	localparam logic [4:0] KIND_BRAKE       = 5'd3;
	localparam logic [4:0] KIND_SERVO_ON    = 5'd4;
	localparam logic [4:0] KIND_SERVO_OFF   = 5'd5;
	localparam logic [4:0] KIND_ERROR_INFO  = 5'd6;
	localparam logic [4:0] KIND_RESET_ERR   = 5'd7;
	localparam logic [4:0] KIND_CHECK_CONN  = 5'd8;
	localparam logic [4:0] KIND_RD_DEV_ID   = 5'd9;
	localparam logic [4:0] KIND_RD_MODE     = 5'd10;
	localparam logic [4:0] KIND_WR_MODE     = 5'd11;
	localparam logic [4:0] KIND_RD_POS      = 5'd12;
	localparam logic [4:0] KIND_WR_POS      = 5'd13;
	localparam logic [4:0] KIND_OFFSET_ENC  = 5'd14;
	localparam logic [4:0] KIND_ROLL_SPEED  = 5'd15;
	localparam logic [4:0] KIND_RD_SPEED    = 5'd16;
	localparam logic [4:0] KIND_UNDEF       = 5'd17;

	localparam int POS_SHIFT   = 7;
	localparam int SPEED_SHIFT = 12;

	typedef struct packed {
		logic [4:0]         command_kind;
		logic signed [31:0] value;
		logic [31:0]        error_code;
		logic [7:0]         source_id;
		logic [7:0]         dest_id;
		logic [15:0]        frame_length;
		logic [15:0]        attribute_code;
		logic [7:0]         check_byte;
		logic               op_mismatch;
		logic               attr_mismatch;
		logic               nak_flag;
		logic               ack_needed;
	} reply_t;

endpackage
`default_nettype wire

@@ hw/rtl/mrfp_in_reg.sv @@
// Input register for received bytes, one transaction deep.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none
module mrfp_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/mrfp_deframer.sv @@
// Frame state, positional field capture and reply classification.
// Depends on mrfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrfp_deframer #(
	parameter int MAX_FRAME = mrfp_pkg::MAX_FRAME_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_s1,
	input  wire logic [7:0]  byte_s1,
	input  wire logic [5:0]  exp_op,
	input  wire logic [15:0] exp_attr,
	input  wire logic        out_free,
	output logic             take,
	output logic             res_valid,
	output mrfp_pkg::reply_t res
);
	import mrfp_pkg::*;

	localparam int PW = $clog2(MAX_FRAME);
	localparam logic [PW-1:0] POS_SRC    = PW'(1);
	localparam logic [PW-1:0] POS_DST    = PW'(2);
	localparam logic [PW-1:0] POS_LEN_HI = PW'(3);
	localparam logic [PW-1:0] POS_LEN_LO = PW'(4);
	localparam logic [PW-1:0] POS_OP     = PW'(5);
	localparam logic [PW-1:0] POS_ATR_HI = PW'(6);
	localparam logic [PW-1:0] POS_ATR_LO = PW'(7);
	localparam logic [PW-1:0] POS_LAST   = PW'(MAX_FRAME - 1);

	logic          in_frame_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    src_q;
	logic [7:0]    dst_q;
	logic [15:0]   len_q;
	logic [7:0]    op_q;
	logic [15:0]   attr_q;
	logic [31:0]   data_q;
	logic [7:0]    chk_q;

	logic          is_end;
	logic          chk_hit;
	logic          drop;
	logic          data_hit;
	logic          has_attr;
	logic [16:0]   pos_x;
	logic [7:0]    chk_now;
	logic [5:0]    op6;
	logic signed [31:0] acc_s;

	assign pos_x    = 17'(pos_q);
	assign has_attr = len_q > 16'd3;
	assign chk_hit  = (pos_q >= POS_OP) && (pos_x == ({1'b0, len_q} + 17'd3));
	assign data_hit = (len_q > 16'd5) && (pos_x <= ({1'b0, len_q} + 17'd2));
	assign drop     = pos_q >= POS_LAST;
	assign is_end   = in_frame_q && (byte_s1 == EOF_BYTE);
	assign take     = valid_s1 && (!is_end || out_free);
	assign res_valid = take && is_end;
	assign chk_now  = chk_hit ? byte_s1 : chk_q;
	assign op6      = op_q[5:0];
	assign acc_s    = signed'(data_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			len_q      <= '0;
			op_q       <= '0;
			attr_q     <= '0;
			data_q     <= '0;
			chk_q      <= '0;
		end else if (take) begin
			if (!in_frame_q) begin
				if (byte_s1 == SOF_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= POS_SRC;
					src_q      <= '0;
					dst_q      <= '0;
					len_q      <= '0;
					op_q       <= '0;
					data_q     <= '0;
					chk_q      <= '0;
				end
			end else begin
				if (chk_hit) begin
					chk_q <= byte_s1;
				end
				if (is_end || drop) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
				end else begin
					case (pos_q)
						POS_SRC:    src_q <= byte_s1;
						POS_DST:    dst_q <= byte_s1;
						POS_LEN_HI: len_q[15:8] <= byte_s1;
						POS_LEN_LO: len_q[7:0] <= byte_s1;
						POS_OP:     op_q <= byte_s1;
						POS_ATR_HI: if (has_attr) attr_q[15:8] <= byte_s1;
						POS_ATR_LO: if (has_attr) attr_q[7:0] <= byte_s1;
						default: begin
							// keep only the last four data bytes
							if (data_hit) data_q <= {data_q[23:0], byte_s1};
						end
					endcase
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

	always_comb begin
		res.command_kind   = KIND_UNDEF;
		res.value          = acc_s;
		res.error_code     = '0;
		res.source_id      = src_q;
		res.dest_id        = dst_q;
		res.frame_length   = len_q;
		res.attribute_code = attr_q;
		res.check_byte     = (len_q < 16'd2) ? len_q[7:0] : chk_now;
		res.op_mismatch    = op6 != exp_op;
		res.attr_mismatch  = has_attr && (attr_q != exp_attr);
		res.nak_flag       = (op_q[7:6] != TOP_ACK_A) && (op_q[7:6] != TOP_ACK_B);
		res.ack_needed     = op_q == ACK_REQ_BYTE;
		unique case (op6) inside
			OP_ERR_INFO, OP_ERR_REPORT: begin
				// error frames carry the code, not a value, and raise no mismatch or NAK flags
				res.command_kind  = KIND_ERROR_INFO;
				res.value         = '0;
				res.error_code    = data_q;
				res.op_mismatch   = 1'b0;
				res.attr_mismatch = 1'b0;
				res.nak_flag      = 1'b0;
			end
			OP_RUN:        res.command_kind = KIND_RUN;
			OP_STOP:       res.command_kind = KIND_STOP;
			OP_ESTOP:      res.command_kind = KIND_ESTOP;
			OP_BRAKE:      res.command_kind = KIND_BRAKE;
			OP_SERVO_ON:   res.command_kind = KIND_SERVO_ON;
			OP_SERVO_OFF:  res.command_kind = KIND_SERVO_OFF;
			OP_RESET_ERR:  res.command_kind = KIND_RESET_ERR;
			OP_CHECK_CONN: res.command_kind = KIND_CHECK_CONN;
			OP_READ: begin
				if (attr_q == ATTR_DEV_ID) begin
					res.command_kind = KIND_RD_DEV_ID;
				end else if (attr_q == ATTR_MODE) begin
					res.command_kind = KIND_RD_MODE;
				end else if (attr_q == ATTR_POS) begin
					res.command_kind = KIND_RD_POS;
					res.value        = acc_s >>> POS_SHIFT;
				end else if (attr_q == ATTR_SPEED) begin
					res.command_kind = KIND_RD_SPEED;
					res.value        = acc_s >>> SPEED_SHIFT;
				end
			end
			OP_WRITE: begin
				if (attr_q == ATTR_MODE) begin
					res.command_kind = KIND_WR_MODE;
				end else if (attr_q == ATTR_WPOS) begin
					res.command_kind = KIND_WR_POS;
					res.value        = acc_s >>> POS_SHIFT;
				end else if (attr_q == ATTR_OFFSET) begin
					res.command_kind = KIND_OFFSET_ENC;
				end else if (attr_q == ATTR_ROLL) begin
					res.command_kind = KIND_ROLL_SPEED;
					res.value        = acc_s >>> SPEED_SHIFT;
				end
			end
			default: res.command_kind = KIND_UNDEF;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/mrfp_out_reg.sv @@
// Result register holding one reply until the consumer takes it.
// Depends on mrfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrfp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire mrfp_pkg::reply_t  res,
	output logic                   out_free,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output mrfp_pkg::reply_t       reply_q
);
	import mrfp_pkg::*;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			reply_q <= res;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/motor_reply_frame_parser_top.sv @@
// Motor reply frame parser: one received byte per cycle unless stalled, one reply per frame not dropped for size.
// reply_valid rises in the cycle after the end byte is accepted.
// Throughput: one byte per cycle; an end byte waits only while the result
// register holds a reply that has not been taken.
// Reset clears frame state (hunting for start) and both expected-code registers.
`timescale 1ns / 1ps
`default_nettype none
module motor_reply_frame_parser_top #(
	parameter int MAX_FRAME = mrfp_pkg::MAX_FRAME_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             reply_valid,
	input  wire logic        reply_ready,
	output logic [4:0]       command_kind,
	output logic signed [31:0] value,
	output logic [31:0]      error_code,
	output logic [7:0]       source_id,
	output logic [7:0]       dest_id,
	output logic [15:0]      frame_length,
	output logic [15:0]      attribute_code,
	output logic [7:0]       check_byte,
	output logic             op_mismatch,
	output logic             attr_mismatch,
	output logic             nak_flag,
	output logic             ack_needed
);
	import mrfp_pkg::*;

	logic [5:0]  exp_op_q;
	logic [15:0] exp_attr_q;
	logic        take;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        res_valid;
	logic        out_free;
	reply_t      res;
	reply_t      reply_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_op_q   <= '0;
			exp_attr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXP_OP:   exp_op_q <= cfg_wdata[5:0];
				CFG_EXP_ATTR: exp_attr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mrfp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx_valid),
		.in_ready (rx_ready),
		.in_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mrfp_deframer #(
		.MAX_FRAME (MAX_FRAME)
	) u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.exp_op    (exp_op_q),
		.exp_attr  (exp_attr_q),
		.out_free  (out_free),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	mrfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (reply_valid),
		.out_ready (reply_ready),
		.reply_q   (reply_q)
	);

	assign command_kind   = reply_q.command_kind;
	assign value          = reply_q.value;
	assign error_code     = reply_q.error_code;
	assign source_id      = reply_q.source_id;
	assign dest_id        = reply_q.dest_id;
	assign frame_length   = reply_q.frame_length;
	assign attribute_code = reply_q.attribute_code;
	assign check_byte     = reply_q.check_byte;
	assign op_mismatch    = reply_q.op_mismatch;
	assign attr_mismatch  = reply_q.attr_mismatch;
	assign nak_flag       = reply_q.nak_flag;
	assign ack_needed     = reply_q.ack_needed;

	// a reply is produced only when the result register can take it
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("reply produced while result register is busy");

	// the deframer consumes only bytes held in the input register
	a_take_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> valid_s1)
		else $error("deframer consumed an empty input register");

	// a finished frame shows up on the reply channel in the next cycle
	a_reply_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> reply_valid)
		else $error("finished frame did not reach the reply channel");

	// the input register is never overwritten while it holds an unconsumed byte
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take) |-> !rx_ready)
		else $error("input register accepted over a pending byte");

endmodule
`default_nettype wire

@@ test/frame_scoreboard_pkg.sv @@
// Scoreboard class for the motor reply frame parser testbench: a byte-level
// deframer predictor and the list of replies it expects. Depends on mrfp_pkg.
`timescale 1ns / 1ps
package frame_scoreboard_pkg;
	import mrfp_pkg::*;

	class frame_scoreboard;
		// expected-code registers as last written
		logic [5:0]  exp_op;
		logic [15:0] exp_attr;

		// deframer state
		bit          in_frame;
		int unsigned pos;
		logic [7:0]  src_id;
		logic [7:0]  dst_id;
		logic [15:0] len_field;
		logic [7:0]  op_byte;
		logic [15:0] attr_field;
		logic [31:0] data_word;
		logic [7:0]  chk_byte;

		reply_t      replies_due[$];
		int unsigned fails;
		int unsigned checked;
		bit [31:0]   kinds_seen;

		function new();
			exp_op = '0;
			exp_attr = '0;
			in_frame = 1'b0;
			pos = 0;
			src_id = '0;
			dst_id = '0;
			len_field = '0;
			op_byte = '0;
			attr_field = '0;
			data_word = '0;
			chk_byte = '0;
			fails = 0;
			checked = 0;
			kinds_seen = '0;
		endfunction

		function void set_reg(logic idx, logic [15:0] data);
			if (idx == CFG_EXP_OP)
				exp_op = data[5:0];
			else
				exp_attr = data;
		endfunction

		function int unsigned due();
			return replies_due.size();
		endfunction

		function reply_t decode_frame();
			reply_t r;
			logic [5:0] op6;
			op6 = op_byte[5:0];
			r = '0;
			r.command_kind = KIND_UNDEF;
			r.value = data_word;
			if (op6 == OP_ERR_INFO || op6 == OP_ERR_REPORT) begin
				r.command_kind = KIND_ERROR_INFO;
				r.value = '0;
				r.error_code = data_word;
			end else begin
				case (op6)
					OP_RUN:        r.command_kind = KIND_RUN;
					OP_STOP:       r.command_kind = KIND_STOP;
					OP_ESTOP:      r.command_kind = KIND_ESTOP;
					OP_BRAKE:      r.command_kind = KIND_BRAKE;
					OP_SERVO_ON:   r.command_kind = KIND_SERVO_ON;
					OP_SERVO_OFF:  r.command_kind = KIND_SERVO_OFF;
					OP_RESET_ERR:  r.command_kind = KIND_RESET_ERR;
					OP_CHECK_CONN: r.command_kind = KIND_CHECK_CONN;
					OP_READ: begin
						if (attr_field == ATTR_DEV_ID)
							r.command_kind = KIND_RD_DEV_ID;
						else if (attr_field == ATTR_MODE)
							r.command_kind = KIND_RD_MODE;
						else if (attr_field == ATTR_POS) begin
							r.command_kind = KIND_RD_POS;
							r.value = $signed(data_word) >>> POS_SHIFT;
						end else if (attr_field == ATTR_SPEED) begin
							r.command_kind = KIND_RD_SPEED;
							r.value = $signed(data_word) >>> SPEED_SHIFT;
						end
					end
					OP_WRITE: begin
						if (attr_field == ATTR_MODE)
							r.command_kind = KIND_WR_MODE;
						else if (attr_field == ATTR_WPOS) begin
							r.command_kind = KIND_WR_POS;
							r.value = $signed(data_word) >>> POS_SHIFT;
						end else if (attr_field == ATTR_OFFSET)
							r.command_kind = KIND_OFFSET_ENC;
						else if (attr_field == ATTR_ROLL) begin
							r.command_kind = KIND_ROLL_SPEED;
							r.value = $signed(data_word) >>> SPEED_SHIFT;
						end
					end
					default: ;
				endcase
				r.op_mismatch = (op6 != exp_op);
				r.attr_mismatch = (len_field > 16'd3) && (attr_field != exp_attr);
				r.nak_flag = !(op_byte[7:6] == TOP_ACK_A || op_byte[7:6] == TOP_ACK_B);
			end
			r.source_id = src_id;
			r.dest_id = dst_id;
			r.frame_length = len_field;
			r.attribute_code = attr_field;
			// tiny lengths point the checksum at the length field itself
			r.check_byte = (len_field < 16'd2) ? len_field[7:0] : chk_byte;
			r.ack_needed = (op_byte == ACK_REQ_BYTE);
			return r;
		endfunction

		// Note one accepted byte; queue a reply when it closes a frame.
		function void accept_byte(logic [7:0] b);
			int unsigned p;
			if (!in_frame) begin
				if (b == SOF_BYTE) begin
					in_frame = 1'b1;
					pos = 1;
					src_id = '0;
					dst_id = '0;
					len_field = '0;
					op_byte = '0;
					data_word = '0;
					chk_byte = '0;
				end
				return;
			end
			p = pos;
			if (p >= 5 && p == 3 + len_field)
				chk_byte = b;
			if (b == EOF_BYTE) begin
				in_frame = 1'b0;
				pos = 0;
				replies_due.push_back(decode_frame());
				return;
			end
			// drop frames that run past the maximum size
			if (p >= MAX_FRAME_DEF - 1) begin
				in_frame = 1'b0;
				pos = 0;
				return;
			end
			case (p)
				1: src_id = b;
				2: dst_id = b;
				3: len_field[15:8] = b;
				4: len_field[7:0] = b;
				5: op_byte = b;
				6: if (len_field > 16'd3) attr_field[15:8] = b;
				7: if (len_field > 16'd3) attr_field[7:0] = b;
				default:
					if (len_field > 16'd5 && p <= len_field + 2)
						data_word = {data_word[23:0], b};
			endcase
			pos = p + 1;
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				$error("reply with no frame pending: command_kind %0d", got.command_kind);
				fails++;
				return;
			end
			want = replies_due.pop_front();
			checked++;
			kinds_seen[want.command_kind] = 1'b1;
			check_field("command_kind", want.command_kind, got.command_kind);
			check_field("value", want.value, got.value);
			check_field("error_code", want.error_code, got.error_code);
			check_field("source_id", want.source_id, got.source_id);
			check_field("dest_id", want.dest_id, got.dest_id);
			check_field("frame_length", want.frame_length, got.frame_length);
			check_field("attribute_code", want.attribute_code, got.attribute_code);
			check_field("check_byte", want.check_byte, got.check_byte);
			check_field("op_mismatch", want.op_mismatch, got.op_mismatch);
			check_field("attr_mismatch", want.attr_mismatch, got.attr_mismatch);
			check_field("nak_flag", want.nak_flag, got.nak_flag);
			check_field("ack_needed", want.ack_needed, got.ack_needed);
		endfunction
	endclass

endpackage

@@ test/tb_top.sv @@
// Testbench top for motor_reply_frame_parser_top: streams directed and random
// reply frames, predicts each reply and checks it. Needs mrfp_pkg and
// frame_scoreboard_pkg.
`timescale 1ns / 1ps
module tb_top;
	import mrfp_pkg::*;
	import frame_scoreboard_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 180;

	localparam logic [7:0] RD_REPLY   = {TOP_ACK_A, OP_READ};
	localparam logic [7:0] WPOS_REPLY = {TOP_ACK_B, OP_WRITE};
	localparam logic [7:0] STOP_NAK   = {2'b00, OP_STOP};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [15:0]        cfg_wdata;
	logic               rx_valid;
	logic               rx_ready;
	logic [7:0]         rx_byte;
	logic               reply_valid;
	logic               reply_ready;
	logic [4:0]         command_kind;
	logic signed [31:0] value;
	logic [31:0]        error_code;
	logic [7:0]         source_id;
	logic [7:0]         dest_id;
	logic [15:0]        frame_length;
	logic [15:0]        attribute_code;
	logic [7:0]         check_byte;
	logic               op_mismatch;
	logic               attr_mismatch;
	logic               nak_flag;
	logic               ack_needed;

	reply_t          reply_bus;
	frame_scoreboard sb;
	logic [7:0]      tx_q[$];
	int unsigned     frame_bytes;
	int unsigned     bytes_sent = 0;
	int unsigned     quiet_cycles = 0;
	int              hold_left = 0;
	bit              sender_gaps = 1'b1;
	bit              sink_stalls = 1'b1;
	logic [5:0]      cur_op = '0;
	logic [15:0]     cur_attr = '0;

	logic [5:0]  op_pool[12] = '{OP_RUN, OP_STOP, OP_ESTOP, OP_BRAKE, OP_SERVO_ON,
		OP_SERVO_OFF, OP_ERR_INFO, OP_ERR_REPORT, OP_RESET_ERR, OP_CHECK_CONN,
		OP_READ, OP_WRITE};
	logic [15:0] attr_pool[7] = '{ATTR_DEV_ID, ATTR_MODE, ATTR_POS, ATTR_SPEED,
		ATTR_WPOS, ATTR_OFFSET, ATTR_ROLL};
	logic [5:0]  op_plan[6] = '{6'h3f, OP_READ, 6'h00, OP_WRITE, 6'h00, OP_ERR_REPORT};
	logic [15:0] attr_plan[6] = '{16'hffff, ATTR_POS, 16'h0000, ATTR_ROLL, 16'h0000,
		ATTR_SPEED};

	motor_reply_frame_parser_top DUT (.*);

	assign reply_bus = {command_kind, value, error_code, source_id, dest_id, frame_length,
		attribute_code, check_byte, op_mismatch, attr_mismatch, nak_flag, ack_needed};

	always #1 clk = ~clk;

	// monitors and watchdog
	always @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			sb.accept_byte(rx_byte);
			bytes_sent++;
		end
		if (reply_valid && reply_ready)
			sb.check_reply(reply_bus);
		if (arst_n && !(rx_valid && rx_ready) && !(reply_valid && reply_ready)) begin
			quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	// reply sink: random stalls plus one long hold-off in the second phase
	initial begin
		reply_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				reply_ready <= 1'b0;
				hold_left--;
			end else begin
				reply_ready <= !(sink_stalls && $urandom_range(0, 99) < 18);
			end
		end
	end

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		// keep the end byte out of the frame body
		if (b == EOF_BYTE)
			b = 8'($urandom_range(128, 255));
		return b;
	endfunction

	function automatic void push_frame(logic [7:0] op, logic [15:0] attr, logic [15:0] len,
			int unsigned stop_at);
		int unsigned last;
		logic [7:0] b;
		last = 3 + len;
		if (stop_at < last)
			last = stop_at;
		tx_q.push_back(SOF_BYTE);
		for (int unsigned p = 1; p <= last; p++) begin
			case (p)
				3: b = len[15:8];
				4: b = len[7:0];
				5: b = op;
				6: b = attr[15:8];
				7: b = attr[7:0];
				default: b = body_byte();
			endcase
			if (p >= 5 && p == 3 + len)
				b = 8'($urandom_range(0, 255));
			tx_q.push_back(b);
		end
		tx_q.push_back(EOF_BYTE);
		frame_bytes += last + 2;
	endfunction

	function automatic void random_frame();
		int unsigned sel;
		int unsigned stop_at;
		logic [5:0]  op6;
		logic [15:0] attr;
		logic [15:0] len;
		sel = $urandom_range(0, 13);
		op6 = (sel < 12) ? op_pool[sel] : ((sel == 12) ? cur_op : 6'($urandom));
		sel = $urandom_range(0, 8);
		attr = (sel < 7) ? attr_pool[sel] : ((sel == 7) ? cur_attr : 16'($urandom));
		len = 16'($urandom_range(5, 13));
		stop_at = 3 + len;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			len = 16'($urandom_range(0, 4));
			stop_at = 3 + len;
		end else if (sel < 20) begin
			stop_at = $urandom_range(1, 2 + len);
		end else if (sel < 23) begin
			// around the maximum frame size, and past it
			case ($urandom_range(0, 3))
				0: len = 16'd123;
				1: len = 16'd124;
				2: len = 16'd125;
				default: len = 16'($urandom_range(126, 400));
			endcase
			stop_at = 3 + len;
		end else if (sel < 26) begin
			len = 16'($urandom);
			stop_at = $urandom_range(1, 20);
		end
		push_frame({2'($urandom), op6}, attr, len, stop_at);
		// line noise between frames while hunting
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 5)) begin
				sel = $urandom_range(0, 255);
				if (sel == SOF_BYTE)
					sel = 0;
				tx_q.push_back(8'(sel));
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (sender_gaps && $urandom_range(0, 99) < 18) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
	endtask

	task automatic send_queue();
		while (tx_q.size() > 0)
			send_byte(tx_q.pop_front());
		rx_valid <= 1'b0;
	endtask

	// hold the sender until every reply is back, then let the pipeline settle
	task automatic drain();
		while (sb.due() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [5:0] op, input logic [15:0] attr);
		logic [15:0] op_word;
		op_word = {10'($urandom), op};
		cfg_we <= 1'b1;
		cfg_index <= CFG_EXP_OP;
		cfg_wdata <= op_word;
		@(posedge clk);
		cfg_index <= CFG_EXP_ATTR;
		cfg_wdata <= attr;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(CFG_EXP_OP, op_word);
		sb.set_reg(CFG_EXP_ATTR, attr);
		cur_op = op;
		cur_attr = attr;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_EXP_OP;
		cfg_wdata = '0;
		rx_valid = 1'b0;
		rx_byte = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at reset register values
		tx_q = {8'h00, 8'hff, EOF_BYTE,
			// speed read with six data bytes, negative last four
			SOF_BYTE, 8'h01, 8'hfe, 8'h00, 8'd11, RD_REPLY, ATTR_SPEED[15:8],
			ATTR_SPEED[7:0], 8'h01, 8'h02, 8'h93, 8'h45, 8'h67, 8'h89, 8'h5a, EOF_BYTE,
			// unsolicited error report
			SOF_BYTE, 8'h10, 8'h20, 8'h00, 8'd9, ACK_REQ_BYTE, 8'h00, 8'h00, 8'hde,
			8'had, 8'hbe, 8'hef, 8'h00, EOF_BYTE,
			// tiny length
			SOF_BYTE, 8'haa, 8'h55, 8'h00, 8'd1, EOF_BYTE,
			// checksum position lands on the end byte
			SOF_BYTE, 8'h01, 8'h02, 8'h00, 8'd5, WPOS_REPLY, ATTR_WPOS[15:8],
			ATTR_WPOS[7:0], EOF_BYTE,
			// start bytes inside a frame are data
			SOF_BYTE, SOF_BYTE, 8'h00, 8'h00, 8'd6, STOP_NAK, 8'h00, 8'h01, SOF_BYTE,
			8'h33, EOF_BYTE,
			// short frame: ends in the header
			SOF_BYTE, 8'h7d, EOF_BYTE};
		send_queue();

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			if (ph == 4) begin
				op_plan[4] = 6'($urandom);
				attr_plan[4] = 16'($urandom);
			end
			program_regs(op_plan[ph], attr_plan[ph]);
			sender_gaps = (ph != 2);
			sink_stalls = (ph != 2);
			if (ph == 1)
				hold_left = HOLD_CYCLES;
			frame_bytes = 0;
			while (frame_bytes < PHASE_BYTES)
				random_frame();
			send_queue();
		end
		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes under 7 register settings; checked %0d replies", bytes_sent,
			sb.checked);
		$display("Command kinds seen: %0d of 18", $countones(sb.kinds_seen));
		if (sb.fails == 0 && sb.due() == 0) begin
			$display("Test completed successfully");
		end else begin
			if (sb.due() != 0)
				$error("%0d replies never arrived", sb.due());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
